### design/grne_pkg.sv
`timescale 1ns / 1ps
package grne_pkg;

   // Default grid dimensions of the store
   localparam int GRID_W_DEF = 64;
   localparam int GRID_H_DEF = 64;

   // Depth of the queue between front and back
   localparam int QDEPTH = 2;

   // func codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_EXPAND = 1'b1;

   // Result kinds
   localparam logic [2:0] KIND_TOWARD  = 3'd0;
   localparam logic [2:0] KIND_SIDE    = 3'd1;
   localparam logic [2:0] KIND_AWAY    = 3'd2;
   localparam logic [2:0] KIND_REACHED = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TARGET_X    = 2'd2;
   localparam logic [1:0] CSR_TARGET_Y    = 2'd3;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_REACH,
      OP_EXPAND
   } op_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_EVAL,
      B_FLUSH
   } back_state_type;

   typedef struct packed {
      logic [6:0] grid_width;
      logic [6:0] grid_height;
      logic [5:0] target_x;
      logic [5:0] target_y;
   } cfg_type;

   // One neighbor, precomputed by the front (coords one wider: can reach 64)
   typedef struct packed {
      logic       ok;
      logic [6:0] x;
      logic [6:0] y;
      logic [2:0] kind;
   } nbr_type;

   typedef struct packed {
      op_type          op;
      logic [5:0]      x;
      logic [5:0]      y;
      logic [15:0]     cost;
      logic [15:0]     ncost;
      logic            blk;
      logic            clm;
      nbr_type [3:0]   nbr;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic        strobe;
      logic [2:0]  kind;
      logic [5:0]  x;
      logic [5:0]  y;
      logic [15:0] cost;
      logic        last;
   } rsp_type;

endpackage

### design/grne_front.sv
`timescale 1ns / 1ps
module grne_front #(
   parameter int GRID_W = grne_pkg::GRID_W_DEF,
   parameter int GRID_H = grne_pkg::GRID_H_DEF
) (
   input  logic                accept,
   input  logic                req_func,
   input  logic [5:0]          req_cell_x,
   input  logic [5:0]          req_cell_y,
   input  logic [15:0]         req_path_cost,
   input  logic                req_blocked_bit,
   input  logic                req_claimed_bit,
   input  grne_pkg::cfg_type   cfg,
   output logic                push,
   output grne_pkg::entry_type push_data
);
   import grne_pkg::*;

   logic [6:0] w;
   logic [6:0] h;
   logic [6:0] x7;
   logic [6:0] y7;
   logic       in_grid;
   logic       reached;

   // columns / rows in use, clipped to the store
   assign w = (int'(cfg.grid_width) < GRID_W) ? cfg.grid_width : 7'(GRID_W);
   assign h = (int'(cfg.grid_height) < GRID_H) ? cfg.grid_height : 7'(GRID_H);

   assign x7 = {1'b0, req_cell_x};
   assign y7 = {1'b0, req_cell_y};

   assign in_grid = (int'(req_cell_x) < GRID_W) && (int'(req_cell_y) < GRID_H);
   assign reached = (req_cell_x == cfg.target_x) && (req_cell_y == cfg.target_y);

   // writes outside the store are dropped here
   assign push = accept && ((req_func == FUNC_EXPAND) || in_grid);

   always_comb begin
      if (req_func == FUNC_WRITE) begin
         push_data.op = OP_WRITE;
      end else if (reached) begin
         push_data.op = OP_REACH;
      end else begin
         push_data.op = OP_EXPAND;
      end
      push_data.x     = req_cell_x;
      push_data.y     = req_cell_y;
      push_data.cost  = req_path_cost;
      push_data.ncost = (req_path_cost == 16'hFFFF) ? req_path_cost
                                                    : req_path_cost + 16'd1;
      push_data.blk   = req_blocked_bit;
      push_data.clm   = req_claimed_bit;

      // up
      push_data.nbr[0].ok   = (req_cell_y != 6'd0) && ((y7 - 7'd1) < h) && (x7 < w);
      push_data.nbr[0].x    = x7;
      push_data.nbr[0].y    = y7 - 7'd1;
      push_data.nbr[0].kind = (req_cell_y == cfg.target_y) ? KIND_SIDE :
                              (req_cell_y > cfg.target_y) ? KIND_TOWARD : KIND_AWAY;
      // down
      push_data.nbr[1].ok   = ((y7 + 7'd1) < h) && (x7 < w);
      push_data.nbr[1].x    = x7;
      push_data.nbr[1].y    = y7 + 7'd1;
      push_data.nbr[1].kind = (req_cell_y == cfg.target_y) ? KIND_SIDE :
                              (req_cell_y > cfg.target_y) ? KIND_AWAY : KIND_TOWARD;
      // left
      push_data.nbr[2].ok   = (req_cell_x != 6'd0) && ((x7 - 7'd1) < w) && (y7 < h);
      push_data.nbr[2].x    = x7 - 7'd1;
      push_data.nbr[2].y    = y7;
      push_data.nbr[2].kind = (req_cell_x == cfg.target_x) ? KIND_SIDE :
                              (req_cell_x > cfg.target_x) ? KIND_TOWARD : KIND_AWAY;
      // right
      push_data.nbr[3].ok   = ((x7 + 7'd1) < w) && (y7 < h);
      push_data.nbr[3].x    = x7 + 7'd1;
      push_data.nbr[3].y    = y7;
      push_data.nbr[3].kind = (req_cell_x == cfg.target_x) ? KIND_SIDE :
                              (req_cell_x > cfg.target_x) ? KIND_AWAY : KIND_TOWARD;
   end

endmodule

### design/grne_queue.sv
`timescale 1ns / 1ps
module grne_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  grne_pkg::entry_type push_data,
   input  logic                pop,
   output grne_pkg::entry_type head,
   output grne_pkg::qstat_type qstat
);
   import grne_pkg::*;

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   entry_type      slot_ff [QDEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff;
   logic [PW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == CW'(QDEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CW'(QDEPTH)) || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

endmodule

### design/grne_back.sv
`timescale 1ns / 1ps
module grne_back #(
   parameter int GRID_W = grne_pkg::GRID_W_DEF,
   parameter int GRID_H = grne_pkg::GRID_H_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  grne_pkg::entry_type head,
   input  grne_pkg::qstat_type qstat,
   output logic                pop,
   output logic                clearing,
   output grne_pkg::rsp_type   rsp
);
   import grne_pkg::*;

   // neighbors reach one past the last writable column/row
   localparam int COLS  = (GRID_W < 65) ? GRID_W : 65;
   localparam int ROWS  = (GRID_H < 65) ? GRID_H : 65;
   localparam int DEPTH = COLS * ROWS;
   localparam int AW    = $clog2(DEPTH);

   // bit 1 blocked, bit 0 claimed
   logic [1:0]      grid_mem [DEPTH];
   logic [1:0]      rd_data_ff;

   back_state_type  state_ff;
   back_state_type  state_in;
   entry_type       cur_ff;
   logic [AW-1:0]   clr_addr_ff;
   logic [AW-1:0]   clr_addr_in;
   logic [1:0]      k_ff;
   logic [1:0]      k_in;
   logic            pend_vld_ff;
   logic            pend_vld_in;
   logic [2:0]      pend_kind_ff;
   logic [2:0]      pend_kind_in;
   logic [5:0]      pend_x_ff;
   logic [5:0]      pend_x_in;
   logic [5:0]      pend_y_ff;
   logic [5:0]      pend_y_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            we;
   logic [AW-1:0]   wr_addr;
   logic [1:0]      wr_data;
   logic            load_cur;
   logic            hit;
   nbr_type         eval_nbr;
   nbr_type         next_nbr;

   function automatic logic [AW-1:0] cell_addr(input logic [6:0] cx, input logic [6:0] cy);
      return AW'(int'(cy) * COLS + int'(cx));
   endfunction

   assign eval_nbr = cur_ff.nbr[k_ff];
   assign next_nbr = cur_ff.nbr[k_ff + 2'd1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!qstat.empty && (head.op == OP_EXPAND)) begin
               state_in = B_READ;
            end
         end
         B_READ: begin
            if (k_ff == 2'd2) begin
               state_in = B_EVAL;
            end
         end
         B_EVAL: begin
            state_in = B_FLUSH;
         end
         B_FLUSH: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_CLEAR;
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cell_addr(next_nbr.x, next_nbr.y);
      we           = 1'b0;
      wr_addr      = cell_addr(eval_nbr.x, eval_nbr.y);
      wr_data      = 2'b01;
      load_cur     = 1'b0;
      hit          = 1'b0;
      clr_addr_in  = clr_addr_ff;
      k_in         = k_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      rsp_in       = '0;
      case (state_ff)
         B_CLEAR: begin
            we          = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = 2'b00;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         B_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               case (head.op)
                  OP_WRITE: begin
                     we      = 1'b1;
                     wr_addr = cell_addr({1'b0, head.x}, {1'b0, head.y});
                     wr_data = {head.blk, head.clm};
                  end
                  OP_REACH: begin
                     rsp_in.strobe = 1'b1;
                     rsp_in.kind   = KIND_REACHED;
                     rsp_in.x      = head.x;
                     rsp_in.y      = head.y;
                     rsp_in.cost   = head.cost;
                     rsp_in.last   = 1'b1;
                  end
                  OP_EXPAND: begin
                     load_cur    = 1'b1;
                     rd_en       = head.nbr[0].ok;
                     rd_addr     = cell_addr(head.nbr[0].x, head.nbr[0].y);
                     k_in        = 2'd0;
                     pend_vld_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_READ, B_EVAL: begin
            // neighbor k_ff's bits are back; claim it if free
            hit = eval_nbr.ok && (rd_data_ff == 2'b00);
            if (hit) begin
               we = 1'b1;
               if (pend_vld_ff) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.kind   = pend_kind_ff;
                  rsp_in.x      = pend_x_ff;
                  rsp_in.y      = pend_y_ff;
                  rsp_in.cost   = cur_ff.ncost;
                  rsp_in.last   = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_kind_in = eval_nbr.kind;
               pend_x_in    = eval_nbr.x[5:0];
               pend_y_in    = eval_nbr.y[5:0];
            end
            if (state_ff == B_READ) begin
               rd_en = next_nbr.ok;
               k_in  = k_ff + 2'd1;
            end
         end
         B_FLUSH: begin
            rsp_in.strobe = 1'b1;
            rsp_in.last   = 1'b1;
            if (pend_vld_ff) begin
               rsp_in.kind = pend_kind_ff;
               rsp_in.x    = pend_x_ff;
               rsp_in.y    = pend_y_ff;
               rsp_in.cost = cur_ff.ncost;
            end else begin
               rsp_in.kind = KIND_NONE;
               rsp_in.x    = cur_ff.x;
               rsp_in.y    = cur_ff.y;
               rsp_in.cost = cur_ff.cost;
            end
            pend_vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_addr_ff <= '0;
         k_ff        <= '0;
         pend_vld_ff <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         k_ff        <= k_in;
         pend_vld_ff <= pend_vld_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      if (load_cur) begin
         cur_ff <= head;
      end
   end

   // grid store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   assign clearing = (state_ff == B_CLEAR);
   assign rsp      = rsp_ff;

   a_flush_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FLUSH) |=> rsp_ff.strobe && rsp_ff.last)
      else $error("flush without final item");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (rd_en && we) |-> (rd_addr != wr_addr))
      else $error("read and claim hit the same cell");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |-> !pend_vld_ff)
      else $error("pending item left over from last expansion");

endmodule

### design/grid_route_neighbor_expand.sv
`timescale 1ns / 1ps
// Grid maze router expansion step. Items enter at start && !busy; results leave on
// rsp_strobe for exactly one cycle each and cannot be held off, so the receiver must
// take every strobe. After reset the grid store (one blocked and one claimed bit per
// cell, min(GRID_W,65) x min(GRID_H,65) cells, 4096 at the defaults) is swept clear one
// cell a cycle with busy high; configuration writes are taken during that sweep.
// The back end reads an expansion's neighbors one at a time on the store's single
// read port, claims the last neighbor, gives the final item, and only then takes the
// next item from the queue. A two-entry queue sits between the front end and the back
// end, so busy is high only while the store is being cleared or the queue is full.
// An expansion gives 1 to 4 items; the final one carries rsp_last.
module grid_route_neighbor_expand #(
   parameter int GRID_W = grne_pkg::GRID_W_DEF,
   parameter int GRID_H = grne_pkg::GRID_H_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // item in
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [15:0] req_path_cost,
   input  logic        req_blocked_bit,
   input  logic        req_claimed_bit,

   // item out
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [5:0]  rsp_next_x,
   output logic [5:0]  rsp_next_y,
   output logic [15:0] rsp_next_cost,
   output logic        rsp_last,

   // configuration
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_write_data
);
   import grne_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       accept;
   logic       push;
   entry_type  push_data;
   entry_type  head;
   qstat_type  qstat;
   logic       pop;
   logic       clearing;
   rsp_type    rsp;

   // configuration registers; the user must write them only while no item is in flight (not enforced here)
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_write_data;
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_write_data;
            CSR_TARGET_X:    cfg_in.target_x    = csr_write_data[5:0];
            CSR_TARGET_Y:    cfg_in.target_y    = csr_write_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= 7'd64;
         cfg_ff.grid_height <= 7'd64;
         cfg_ff.target_x    <= 6'd0;
         cfg_ff.target_y    <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // busy while the store is being cleared or the queue has no room
   assign busy   = clearing || qstat.full;
   assign accept = start && !busy;

   // front: classify the item, precompute neighbors, range tests and direction
   grne_front #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_front (
      .accept          (accept),
      .req_func        (req_func),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_path_cost   (req_path_cost),
      .req_blocked_bit (req_blocked_bit),
      .req_claimed_bit (req_claimed_bit),
      .cfg             (cfg_ff),
      .push            (push),
      .push_data       (push_data)
   );

   // queue decoupling front and back
   grne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // back: owns the grid store, claims free neighbors, emits items
   grne_back #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .clearing (clearing),
      .rsp      (rsp)
   );

   assign rsp_strobe    = rsp.strobe;
   assign rsp_kind      = rsp.kind;
   assign rsp_next_x    = rsp.x;
   assign rsp_next_y    = rsp.y;
   assign rsp_next_cost = rsp.cost;
   assign rsp_last      = rsp.last;

endmodule
